### design/lpmt_pkg.sv
`default_nettype none

package lpmt_pkg;

    localparam int LPMT_VALUE_BITS  = 10;
    localparam int LPMT_LENGTH_BITS = 16;

    typedef enum logic
    {
        OP_APPEND = 1'b0,
        OP_QUERY  = 1'b1
    } lpmt_op_t;

endpackage

`default_nettype wire

### design/lpmt_ifs.sv
`default_nettype none

interface lpmt_item_if #(
    parameter int VALUE_BITS = lpmt_pkg::LPMT_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface lpmt_result_if #(
    parameter int LENGTH_BITS = lpmt_pkg::LPMT_LENGTH_BITS
);
    logic                   valid;
    logic                   ready;
    logic [LENGTH_BITS-1:0] length;
    logic                   was_query;

    modport source (output valid, output length, output was_query, input ready);
    modport sink   (input valid, input length, input was_query, output ready);
endinterface

`default_nettype wire

### design/lpmt_ram.sv
`default_nettype none

module lpmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/lpmt_max_unit.sv
`default_nettype none

module lpmt_max_unit #(
    parameter int LENGTH_BITS = lpmt_pkg::LPMT_LENGTH_BITS
) (
    input  logic [LENGTH_BITS-1:0] a,
    input  logic [LENGTH_BITS-1:0] b,
    input  logic                   a_en,
    output logic [LENGTH_BITS-1:0] mx,
    output logic [LENGTH_BITS-1:0] inc
);

    logic [LENGTH_BITS:0] sum;

    always_comb
    begin
        mx  = (a_en && (a > b)) ? a : b;
        sum = {1'b0, mx} + {{LENGTH_BITS{1'b0}}, 1'b1};
        // saturate at the top of the length range
        inc = sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
    end

endmodule

`default_nettype wire

### design/lis_prefix_max_tree_core.sv
// one word at a time; next word taken the cycle after the result is registered
// one tree memory (a read and a write port) walked level by level and one shared
// max/increment unit; reset: after rst_n rises all 2^(VALUE_BITS+1) tree nodes
// (2048 by default) are cleared, item.ready low meanwhile; result.valid low from reset
`default_nettype none

module lis_prefix_max_tree_core #(
    parameter int VALUE_BITS  = lpmt_pkg::LPMT_VALUE_BITS,
    parameter int LENGTH_BITS = lpmt_pkg::LPMT_LENGTH_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    lpmt_item_if.sink   item,
    lpmt_result_if.source result
);
    import lpmt_pkg::*;

    localparam int NODE_BITS = VALUE_BITS + 1;
    localparam int DEPTH     = 2 ** NODE_BITS;
    localparam int STEP_W    = $clog2(VALUE_BITS + 2);

    localparam logic [STEP_W-1:0]    LAST_READ = STEP_W'(VALUE_BITS);
    localparam logic [NODE_BITS-1:0] ADDR_ROOT = NODE_BITS'(1);

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RAISE,
        S_FINISH
    } state_t;

    state_t                 state_reg,     state_next;
    logic [STEP_W-1:0]      step_reg,      step_next;
    logic [NODE_BITS-1:0]   hi_reg,        hi_next;
    logic [NODE_BITS-1:0]   wr_addr_reg,   wr_addr_next;
    logic [NODE_BITS-1:0]   clr_reg,       clr_next;
    logic [VALUE_BITS-1:0]  val_reg,       val_next;
    logic [LENGTH_BITS-1:0] best_reg,      best_next;
    logic [LENGTH_BITS-1:0] len_reg,       len_next;
    logic                   op_reg,        op_next;
    logic                   full_reg,      full_next;
    logic                   pend_reg,      pend_next;
    logic                   res_valid_reg, res_valid_next;
    logic [LENGTH_BITS-1:0] res_len_reg,   res_len_next;
    logic                   res_query_reg, res_query_next;

    logic                   rd_en;
    logic [NODE_BITS-1:0]   rd_addr;
    logic [LENGTH_BITS-1:0] rd_data;
    logic                   wr_en;
    logic [NODE_BITS-1:0]   wr_addr;
    logic [LENGTH_BITS-1:0] wr_data;
    logic [LENGTH_BITS-1:0] unit_b;
    logic [LENGTH_BITS-1:0] unit_mx;
    logic [LENGTH_BITS-1:0] unit_inc;

    lpmt_ram #(
        .WIDTH (LENGTH_BITS),
        .DEPTH (DEPTH)
    ) u_tree (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign unit_b = (state_reg == S_RAISE) ? len_reg : best_reg;

    lpmt_max_unit #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_max (
        .a    (rd_data),
        .b    (unit_b),
        .a_en (pend_reg),
        .mx   (unit_mx),
        .inc  (unit_inc)
    );

    assign item.ready       = (state_reg == S_IDLE);
    assign result.valid     = res_valid_reg;
    assign result.length    = res_len_reg;
    assign result.was_query = res_query_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        hi_next        = hi_reg;
        wr_addr_next   = wr_addr_reg;
        clr_next       = clr_reg;
        val_next       = val_reg;
        best_next      = best_reg;
        len_next       = len_reg;
        op_next        = op_reg;
        full_next      = full_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg;
        res_len_next   = res_len_reg;
        res_query_next = res_query_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + NODE_BITS'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next   = item.opcode;
                    val_next  = item.value;
                    best_next = '0;
                    pend_next = 1'b0;
                    step_next = '0;
                    // leaf index of the exclusive end of the prefix; a full prefix wraps to
                    // the first leaf and is served by the root instead
                    if (item.opcode == OP_QUERY)
                    begin
                        hi_next   = {1'b1, VALUE_BITS'(item.value + 1'b1)};
                        full_next = &item.value;
                    end
                    else
                    begin
                        hi_next   = {1'b1, item.value};
                        full_next = 1'b0;
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                best_next = unit_mx;
                pend_next = 1'b0;
                step_next = step_reg + STEP_W'(1);
                if (step_reg < LAST_READ)
                begin
                    // odd end index: the left sibling lies wholly inside the prefix
                    rd_en     = hi_reg[0];
                    rd_addr   = {hi_reg[NODE_BITS-1:1], 1'b0};
                    pend_next = hi_reg[0];
                    hi_next   = hi_reg >> 1;
                end
                else if (step_reg == LAST_READ)
                begin
                    rd_en     = full_reg;
                    rd_addr   = ADDR_ROOT;
                    pend_next = full_reg;
                end
                else
                begin
                    step_next = '0;
                    if (op_reg == OP_QUERY)
                    begin
                        len_next   = unit_mx;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        len_next   = unit_inc;
                        hi_next    = {1'b1, val_reg};
                        state_next = S_RAISE;
                    end
                end
            end
            S_RAISE:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wr_addr_reg;
                    wr_data = unit_mx;
                end
                if (step_reg <= LAST_READ)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = hi_reg;
                    pend_next    = 1'b1;
                    wr_addr_next = hi_reg;
                    hi_next      = hi_reg >> 1;
                    step_next    = step_reg + STEP_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_len_next   = len_reg;
                    res_query_next = op_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg        <= hi_next;
        wr_addr_reg   <= wr_addr_next;
        val_reg       <= val_next;
        best_reg      <= best_next;
        len_reg       <= len_next;
        op_reg        <= op_next;
        full_reg      <= full_next;
        res_len_reg   <= res_len_next;
        res_query_reg <= res_query_next;
    end

endmodule

`default_nettype wire

### design/lpmt_checker.sv
`default_nettype none

module lpmt_checker #(
    parameter int LENGTH_BITS = lpmt_pkg::LPMT_LENGTH_BITS
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input logic [LENGTH_BITS-1:0] result_length,
    input logic                   result_was_query
);

    logic item_take;

    assign item_take = item_valid && item_ready;

    // a waiting result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_length)
            && $stable(result_was_query))
        else $error("result word changed while stalled");

    // one word in flight: no new word taken straight after one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> !item_ready)
        else $error("second word taken while busy");

    // the tree walk comes between a taken word and its result: no result rises straight after a take
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> !$rose(result_valid) ##1 !$rose(result_valid))
        else $error("result appeared too soon after a word was taken");

    // clearing pass follows reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !item_ready && !result_valid)
        else $error("block active right after reset");

endmodule

bind lis_prefix_max_tree_core lpmt_checker #(
    .LENGTH_BITS (LENGTH_BITS)
) u_lpmt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_length    (result.length),
    .result_was_query (result.was_query)
);

`default_nettype wire
